FILE: sv/masked_can_rule_matcher_defines.svh
// Assertion helpers for the checker file.
`ifndef MASKED_CAN_RULE_MATCHER_DEFINES_SVH
`define MASKED_CAN_RULE_MATCHER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mcrm_pkg.sv
package mcrm_pkg;

    localparam int RULE_SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS        = 16;
    localparam int RES_CNT_W          = 5;

    localparam logic CFG_ENGINE_ON = 1'b0;
    localparam logic CFG_SUPPORTED = 1'b1;

    typedef enum logic [2:0] {
        KIND_MATCH  = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_ENABLE = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NO_MATCH    = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_UNSUPPORTED = 3'd3,
        STAT_NOT_FOUND   = 3'd4,
        STAT_INACTIVE    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [28:0] ident;
        logic [28:0] ident_mask;
        logic [63:0] data;
        logic [63:0] cmp_mask;
        logic [3:0]  len;
        logic [4:0]  action;
    } rule_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rule_id;
        logic [28:0] ident;
        logic [28:0] ident_mask;
        logic [63:0] payload;
        logic [63:0] payload_mask;
        logic [3:0]  byte_count;
        logic [4:0]  action_code;
        logic        enable_flag;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  result_id;
        logic [3:0]  slot_index;
        logic [4:0]  result_action;
    } result_t;

    // Byte-enable style mask covering the first n data bytes.
    function automatic logic [63:0] len_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < n)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: sv/mcrm_if.sv
interface mcrm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  rule_id;
    logic [28:0] ident;
    logic [28:0] ident_mask;
    logic [63:0] payload;
    logic [63:0] payload_mask;
    logic [3:0]  byte_count;
    logic [4:0]  action_code;
    logic        enable_flag;

    modport source (
        output valid, kind, rule_id, ident, ident_mask, payload, payload_mask,
               byte_count, action_code, enable_flag,
        input  ready
    );
    modport sink (
        input  valid, kind, rule_id, ident, ident_mask, payload, payload_mask,
               byte_count, action_code, enable_flag,
        output ready
    );
endinterface

interface mcrm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  result_id;
    logic [3:0]  slot_index;
    logic [4:0]  result_action;
    logic        last;

    modport source (
        output valid, status, result_id, slot_index, result_action, last,
        input  ready
    );
    modport sink (
        input  valid, status, result_id, slot_index, result_action, last,
        output ready
    );
endinterface

FILE: sv/mcrm_rule_check.sv
module mcrm_rule_check
    import mcrm_pkg::*;
(
    input  rule_t       rule,
    input  logic        live,
    input  logic [28:0] ident,
    input  logic [63:0] data,
    input  logic [3:0]  byte_count,
    output logic        hit
);

    logic id_ok;
    logic data_ok;

    always_comb
    begin
        id_ok = ((ident ^ rule.ident) & rule.ident_mask) == 29'd0;
        // A rule with zero compare length ignores the data entirely.
        data_ok = (rule.len == 4'd0) ||
                  ((byte_count >= rule.len) &&
                   (((data ^ rule.data) & rule.cmp_mask & len_mask(rule.len)) == 64'd0));
        hit = live && id_ok && data_ok;
    end

endmodule

FILE: sv/masked_can_rule_matcher.sv
// Rule table for masked message filtering. Each command item (match, add,
// remove, set enable, clear) is taken one at a time. Match, add, remove and
// set enable walk the rule memory one slot per cycle; add, remove and set
// enable stop at the slot they act on, and every item also waits whenever a
// result cannot be handed on because the output register is still full.
// Clear, an inactive engine and an unsupported add skip the walk. A new item
// is accepted while the previous final result still waits in the output
// register. Slot occupancy and enable bits sit in flip-flops that reset
// clears, so no clearing pass over the memory is needed after reset.
module masked_can_rule_matcher
    import mcrm_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    mcrm_cmd_if.sink    cmd,
    mcrm_res_if.source  res
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(RULE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_SLOTS - 1);

    logic                  engine_on_reg;
    logic [31:0]           supported_reg;
    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]      tgt_idx_reg, tgt_idx_next;
    logic [RULE_SLOTS-1:0] valid_reg;
    logic [RULE_SLOTS-1:0] on_reg;
    logic [7:0]            next_id_reg;
    logic [RES_CNT_W-1:0]  hits_reg, hits_next;
    result_t               res_reg, res_next;
    logic                  res_vld_reg, res_vld_next;
    logic                  out_vld_reg;
    result_t               out_reg;
    logic                  out_last_reg;

    rule_t                 mem [RULE_SLOTS];
    rule_t                 q_reg;
    rule_t                 wr_rule;

    logic                  accept;
    logic                  out_free;
    logic                  mem_re;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_idx;
    logic                  stall;
    logic                  hit;
    logic                  id_hit;
    logic                  at_last;
    logic                  done;
    logic                  commit;
    logic                  out_ld;
    result_t               out_data;
    logic                  out_last;
    logic [7:0]            new_id;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && (state_reg == ST_IDLE);
    assign out_free  = !out_vld_reg || res.ready;
    assign rd_idx    = rd_cnt_reg[IDX_W-1:0];
    assign at_last   = (chk_idx_reg == LAST_IDX);
    assign id_hit    = valid_reg[chk_idx_reg] && (q_reg.id == cmd_reg.rule_id);
    assign new_id    = (cmd_reg.rule_id == 8'd0) ? next_id_reg : cmd_reg.rule_id;

    mcrm_rule_check u_check (
        .rule       (q_reg),
        .live       (valid_reg[chk_idx_reg] && on_reg[chk_idx_reg]),
        .ident      (cmd_reg.ident),
        .data       (cmd_reg.payload),
        .byte_count (cmd_reg.byte_count),
        .hit        (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_on_reg <= 1'b0;
            supported_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENGINE_ON: engine_on_reg <= cfg_data[0];
                CFG_SUPPORTED: supported_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        tgt_idx_next = tgt_idx_reg;
        hits_next    = hits_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg;
        mem_re       = 1'b0;
        stall        = 1'b0;
        done         = 1'b0;
        commit       = 1'b0;
        out_ld       = 1'b0;
        out_data     = res_reg;
        out_last     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_cnt_next  = '0;
                    hits_next    = '0;
                    res_vld_next = 1'b0;
                    if (!engine_on_reg)
                    begin
                        res_next   = result_t'{STAT_INACTIVE, 8'd0, 4'd0, 5'd0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        case (cmd.kind) inside
                            KIND_MATCH, KIND_REMOVE, KIND_ENABLE:
                            begin
                                state_next = ST_SCAN;
                            end
                            KIND_ADD:
                            begin
                                if (!supported_reg[cmd.action_code])
                                begin
                                    res_next   = result_t'{STAT_UNSUPPORTED, 8'd0, 4'd0, 5'd0};
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                res_next   = result_t'{STAT_OK, 8'd0, 4'd0, 5'd0};
                                state_next = ST_DONE;
                            end
                            default:
                            begin
                                // Undefined commands are dropped without a result.
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            ST_SCAN:
            begin
                // A new match can only displace the held one if the output is free.
                stall = chk_vld_reg && (cmd_reg.kind == KIND_MATCH) && hit &&
                        res_vld_reg && !out_free;
                mem_re = !stall && (rd_cnt_reg != SLOT_CNT);
                if (mem_re)
                begin
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    chk_idx_next = rd_idx;
                end
                chk_vld_next = stall ? chk_vld_reg : mem_re;

                if (chk_vld_reg && !stall)
                begin
                    case (cmd_reg.kind) inside
                        KIND_MATCH:
                        begin
                            if (hit)
                            begin
                                if (res_vld_reg)
                                begin
                                    out_ld   = 1'b1;
                                    out_data = res_reg;
                                    out_last = 1'b0;
                                end
                                res_next = result_t'{STAT_OK, q_reg.id, 4'(chk_idx_reg),
                                                     q_reg.action};
                                res_vld_next = 1'b1;
                                hits_next    = hits_reg + 1'b1;
                                if (hits_reg == RES_CNT_W'(MAX_RESULTS - 1))
                                begin
                                    done = 1'b1;
                                end
                            end
                            if (at_last)
                            begin
                                if (!hit && !res_vld_reg)
                                begin
                                    res_next = result_t'{STAT_NO_MATCH, 8'd0, 4'd0, 5'd0};
                                end
                                done = 1'b1;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (!valid_reg[chk_idx_reg])
                            begin
                                res_next     = result_t'{STAT_OK, new_id, 4'(chk_idx_reg), 5'd0};
                                tgt_idx_next = chk_idx_reg;
                                done         = 1'b1;
                            end
                            else if (at_last)
                            begin
                                res_next = result_t'{STAT_FULL, 8'd0, 4'd0, 5'd0};
                                done     = 1'b1;
                            end
                        end
                        KIND_REMOVE, KIND_ENABLE:
                        begin
                            if (id_hit)
                            begin
                                res_next = result_t'{STAT_OK, cmd_reg.rule_id,
                                                     4'(chk_idx_reg), 5'd0};
                                tgt_idx_next = chk_idx_reg;
                                done         = 1'b1;
                            end
                            else if (at_last)
                            begin
                                res_next = result_t'{STAT_NOT_FOUND, 8'd0, 4'd0, 5'd0};
                                done     = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
                if (done)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_ld     = 1'b1;
                    out_data   = res_reg;
                    out_last   = 1'b1;
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            chk_vld_reg <= 1'b0;
            hits_reg    <= '0;
            res_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            chk_vld_reg <= chk_vld_next;
            hits_reg    <= hits_next;
            res_vld_reg <= res_vld_next;
            if (out_ld)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        tgt_idx_reg <= tgt_idx_next;
        res_reg     <= res_next;
        if (accept)
        begin
            cmd_reg <= '{cmd.kind, cmd.rule_id, cmd.ident, cmd.ident_mask, cmd.payload,
                         cmd.payload_mask, cmd.byte_count, cmd.action_code,
                         cmd.enable_flag};
        end
        if (out_ld)
        begin
            out_reg      <= out_data;
            out_last_reg <= out_last;
        end
    end

    // Table updates land when the final result of the item is handed on.
    assign mem_we = commit && engine_on_reg && (cmd_reg.kind == KIND_ADD) &&
                    (res_reg.status == STAT_OK);

    always_comb
    begin
        wr_rule.id         = res_reg.result_id;
        wr_rule.ident      = cmd_reg.ident;
        wr_rule.ident_mask = cmd_reg.ident_mask;
        wr_rule.data       = cmd_reg.payload;
        wr_rule.cmp_mask   = cmd_reg.payload_mask;
        wr_rule.len        = (cmd_reg.byte_count > 4'd8) ? 4'd8 : cmd_reg.byte_count;
        wr_rule.action     = cmd_reg.action_code;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tgt_idx_reg] <= wr_rule;
        end
        if (mem_re)
        begin
            q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            on_reg      <= '0;
            next_id_reg <= 8'd1;
        end
        else if (commit && engine_on_reg)
        begin
            case (cmd_reg.kind)
                KIND_CLEAR:
                begin
                    valid_reg   <= '0;
                    on_reg      <= '0;
                    next_id_reg <= 8'd1;
                end
                KIND_ADD:
                begin
                    if (res_reg.status == STAT_OK)
                    begin
                        valid_reg[tgt_idx_reg] <= 1'b1;
                        on_reg[tgt_idx_reg]    <= 1'b1;
                        if (cmd_reg.rule_id == 8'd0)
                        begin
                            next_id_reg <= (next_id_reg == 8'd255) ? 8'd1
                                                                   : next_id_reg + 8'd1;
                        end
                    end
                end
                KIND_REMOVE:
                begin
                    if (res_reg.status == STAT_OK)
                    begin
                        valid_reg[tgt_idx_reg] <= 1'b0;
                        on_reg[tgt_idx_reg]    <= 1'b0;
                    end
                end
                KIND_ENABLE:
                begin
                    if (res_reg.status == STAT_OK)
                    begin
                        on_reg[tgt_idx_reg] <= cmd_reg.enable_flag;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res.valid         = out_vld_reg;
    assign res.status        = out_reg.status;
    assign res.result_id     = out_reg.result_id;
    assign res.slot_index    = out_reg.slot_index;
    assign res.result_action = out_reg.result_action;
    assign res.last          = out_last_reg;

endmodule

FILE: sv/mcrm_checker.sv
`include "masked_can_rule_matcher_defines.svh"

module mcrm_checker
    import mcrm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] res_status,
    input logic [7:0] res_result_id,
    input logic [4:0] res_result_action,
    input logic       res_last
);

    // Only a match gives more than one result, and those carry a stored rule id.
    `MCRM_ASSERT_NOW(a_mid_result_ok, res_valid && !res_last, (res_status == STAT_OK) && (res_result_id != 8'd0), "non-final result is not a matched rule")

    // Every failure answer is a single, otherwise empty result.
    `MCRM_ASSERT_NOW(a_fail_is_final, res_valid && (res_status != STAT_OK), res_last && (res_result_id == 8'd0) && (res_result_action == 5'd0), "failure result carries data or is not final")

    `MCRM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_result_id) && $stable(res_last), "stalled result changed")

endmodule

bind masked_can_rule_matcher mcrm_checker u_mcrm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_status        (res.status),
    .res_result_id     (res.result_id),
    .res_result_action (res.result_action),
    .res_last          (res.last)
);
